// ----- hw/rtl/attribute_value_matcher_core_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ATTRIBUTE_VALUE_MATCHER_CORE_MACROS_SVH
`define ATTRIBUTE_VALUE_MATCHER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AVM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Implication checked at every clock edge outside reset.
`define AVM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define AVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/avm_pkg.sv -----
package avm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 32;
  localparam int unsigned PAT_REGS        = 4;
  localparam int unsigned PAT_BITS        = 64 * PAT_REGS;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned MODE_W          = 3;
  localparam int unsigned CNT_W           = 6;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned ADDR_W          = 6;
  localparam int unsigned REG_IDX_W       = 3;

  localparam logic [7:0]       SPACE_BYTE = 8'h20;
  localparam logic [7:0]       TAB_BYTE   = 8'h09;
  localparam logic [CNT_W-1:0] COUNT_SAT  = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALWAYS = 3'd0,
    MODE_EXACT  = 3'd1,
    MODE_PREFIX = 3'd2,
    MODE_SUFFIX = 3'd3,
    MODE_WORD   = 3'd4,
    MODE_SUBSTR = 3'd5
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_LENGTH   = 3'd1,
    REG_PAT_LOW  = 3'd2,
    REG_PAT_SEC  = 3'd3,
    REG_PAT_THD  = 3'd4,
    REG_PAT_HIGH = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [LEN_W-1:0]    plen;
    logic [PAT_BITS-1:0] pattern;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == COUNT_SAT) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- hw/rtl/attribute_value_matcher_core.sv -----
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_value_byte, in_byte_present, in_value_end
// out       out_valid / out_ready out_matched (one beat per ending item)
// cfg       psel/penable, pready  paddr, pwdata (write), prdata (read), 64-bit regs
//
// One item per cycle sustained unless an ending item waits on a stalled output:
// an item is registered on accept and judged by the match logic when it fires,
// which writes the match state and the result register in the same edge.
// Reset (rst_n low, synchronous) empties both stages and clears the match state.
// A stalled output only holds back an ending item; other items keep flowing.
module attribute_value_matcher_core
  import avm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_value_byte,
  input  logic              in_byte_present,
  input  logic              in_value_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_matched,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic       inq_valid_r;
  logic [7:0] inq_byte_r;
  logic       inq_present_r;
  logic       inq_end_r;
  logic       out_valid_r;
  logic       matched_r;
  logic       matched_nxt;
  logic       fire;

  avm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held item unless it ends a value and the result slot is blocked.
  assign fire     = inq_valid_r && (!inq_end_r || !out_valid_r || out_ready);
  assign in_ready = !inq_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte_r    <= in_value_byte;
      inq_present_r <= in_byte_present;
      inq_end_r     <= in_value_end;
    end
  end

  avm_match_core #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .value_byte   (inq_byte_r),
    .byte_present (inq_present_r),
    .value_end    (inq_end_r),
    .cfg          (cfg),
    .matched      (matched_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && inq_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && inq_end_r) begin
      matched_r <= matched_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = matched_r;

endmodule

// ----- hw/rtl/avm_cfg_regs.sv -----
module avm_cfg_regs
  import avm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [MODE_W-1:0]   mode_r;
  logic [LEN_W-1:0]    plen_r;
  logic [PAT_BITS-1:0] pat_r;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      plen_r <= '0;
      pat_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:     mode_r           <= pwdata[MODE_W-1:0];
        REG_LENGTH:   plen_r           <= pwdata[LEN_W-1:0];
        REG_PAT_LOW:  pat_r[0*64 +: 64] <= pwdata;
        REG_PAT_SEC:  pat_r[1*64 +: 64] <= pwdata;
        REG_PAT_THD:  pat_r[2*64 +: 64] <= pwdata;
        REG_PAT_HIGH: pat_r[3*64 +: 64] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:     prdata = DATA_W'(mode_r);
      REG_LENGTH:   prdata = DATA_W'(plen_r);
      REG_PAT_LOW:  prdata = pat_r[0*64 +: 64];
      REG_PAT_SEC:  prdata = pat_r[1*64 +: 64];
      REG_PAT_THD:  prdata = pat_r[2*64 +: 64];
      REG_PAT_HIGH: prdata = pat_r[3*64 +: 64];
      default:      prdata = '0;
    endcase
  end

  assign cfg.mode    = mode_r;
  assign cfg.plen    = plen_r;
  assign cfg.pattern = pat_r;

endmodule

// ----- hw/rtl/avm_match_core.sv -----
module avm_match_core
  import avm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] value_byte,
  input  logic       byte_present,
  input  logic       value_end,
  input  cfg_t       cfg,
  output logic       matched
);

  localparam int unsigned PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [7:0]       win_r [PATTERN_MAX];
  logic [7:0]       win_post [PATTERN_MAX];
  logic [CNT_W-1:0] seen_r, seen_post;
  logic             pe_r, pe_post;
  logic             sf_r, sf_post;
  logic [CNT_W-1:0] wp_r, wp_post;
  logic             we_r, we_post;
  logic             wf_r, wf_post, wf_fin;
  logic [LEN_W-1:0] len;
  logic             is_ws;
  logic             prefix_mis;
  logic             word_mis;
  logic             tail_hit;

  function automatic logic [7:0] pat_byte(input cfg_t c, input logic [PIDX_W-1:0] i);
    pat_byte = c.pattern[8*i +: 8];
  endfunction

  function automatic logic word_close(input logic [CNT_W-1:0] wp, input logic we,
                                      input logic [LEN_W-1:0] l);
    word_close = (wp != '0) && we && (wp == CNT_W'(l));
  endfunction

  assign len = (cfg.plen > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : cfg.plen;
  assign is_ws = (value_byte == SPACE_BYTE) || (value_byte == TAB_BYTE);

  assign prefix_mis = (seen_r < CNT_W'(len)) &&
                      (value_byte != pat_byte(cfg, seen_r[PIDX_W-1:0]));
  assign word_mis   = (wp_r >= CNT_W'(len)) ||
                      (value_byte != pat_byte(cfg, wp_r[PIDX_W-1:0]));

  // Window as it stands after this beat's byte, if any.
  always_comb begin
    win_post[0] = byte_present ? value_byte : win_r[0];
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_post[k] = byte_present ? win_r[k-1] : win_r[k];
    end
  end

  // Suffix test: window entry k against pattern byte len-1-k, for k below len.
  always_comb begin
    logic [LEN_W-1:0] ridx;
    logic             ok;
    ok = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      ridx = len - LEN_W'(k) - LEN_W'(1);
      if (LEN_W'(k) < len && win_post[k] != pat_byte(cfg, ridx[PIDX_W-1:0])) begin
        ok = 1'b0;
      end
    end
    tail_hit = ok && (seen_post >= CNT_W'(len));
  end

  always_comb begin
    seen_post = byte_present ? sat_inc(seen_r) : seen_r;
    pe_post   = pe_r && !(byte_present && prefix_mis);
    sf_post   = sf_r || (byte_present && tail_hit);
    wp_post   = wp_r;
    we_post   = we_r;
    wf_post   = wf_r;
    if (byte_present) begin
      if (is_ws) begin
        wf_post = wf_r || word_close(wp_r, we_r, len);
        wp_post = '0;
        we_post = 1'b1;
      end else begin
        wp_post = sat_inc(wp_r);
        we_post = we_r && !word_mis;
      end
    end
    wf_fin = wf_post || word_close(wp_post, we_post, len);
  end

  always_comb begin
    unique case (mode_t'(cfg.mode))
      MODE_ALWAYS: matched = 1'b1;
      MODE_EXACT:  matched = pe_post && (seen_post == CNT_W'(len));
      MODE_PREFIX: matched = pe_post && (seen_post >= CNT_W'(len));
      MODE_SUFFIX: matched = tail_hit;
      MODE_WORD:   matched = wf_fin;
      MODE_SUBSTR: matched = sf_post || (len == '0);
      default:     matched = 1'b0;
    endcase
  end

  // Window holds only value bytes wherever the suffix test looks.
  always_ff @(posedge clk) begin
    if (fire && byte_present) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_r[k] <= win_post[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pe_r   <= 1'b1;
      sf_r   <= 1'b0;
      wp_r   <= '0;
      we_r   <= 1'b1;
      wf_r   <= 1'b0;
    end else if (fire) begin
      if (value_end) begin
        seen_r <= '0;
        pe_r   <= 1'b1;
        sf_r   <= 1'b0;
        wp_r   <= '0;
        we_r   <= 1'b1;
        wf_r   <= 1'b0;
      end else begin
        seen_r <= seen_post;
        pe_r   <= pe_post;
        sf_r   <= sf_post;
        wp_r   <= wp_post;
        we_r   <= we_post;
        wf_r   <= wf_post;
      end
    end
  end

endmodule

// ----- hw/rtl/avm_checker.sv -----
`include "attribute_value_matcher_core_macros.svh"

module avm_checker
  import avm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_matched,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  reg_idx_t pidx;
  logic     mode_wr;
  logic     mode_rd;

  assign pidx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
  assign mode_wr = psel && penable && pwrite && pready && (pidx == REG_MODE);
  assign mode_rd = psel && !pwrite && (pidx == REG_MODE);

  // A free result slot must never block the input side.
  `AVM_ASSERT_IMPLIES(a_in_not_blocked, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled while output side is free")

  `AVM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_matched), "stalled result beat changed")

  `AVM_ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready, "pready dropped")

  `AVM_ASSERT_NEXT(a_mode_readback, clk, rst_n, mode_wr, !mode_rd || (prdata[2:0] == $past(pwdata[2:0])), "mode register readback mismatch")

endmodule

bind attribute_value_matcher_core avm_checker u_avm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_matched (out_matched),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);
